FILE: rtl/pec_pkg.sv
// Shared constants, types and character helpers for the percent-encoding codec.
package pec_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam int unsigned MAX_RES = 3;

  // Decode phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // Results of one input item, first result in entry 0
  typedef struct packed {
    logic [1:0]                 cnt;
    logic [MAX_RES-1:0][7:0]    bytes;
    logic                       last;
  } pec_burst_t;

  function automatic logic is_unreserved(input logic [7:0] c);
    logic r;
    r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A) || c == 8'h2D || c == 8'h2E ||
        c == 8'h5F || c == 8'h7E;
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
        (c >= 8'h61 && c <= 8'h66);
    return r;
  endfunction

  // Valid only for hex digit characters; letters are 0x4x/0x6x with low nibble 1..6
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] r;
    r = c[6] ? c[3:0] + 4'd9 : c[3:0];
    return r;
  endfunction

endpackage

FILE: rtl/pec_step.sv
// Single-pass encode/decode logic: results and next decode state for one byte.
module pec_step (
  input  logic              mode_i,
  input  logic [1:0]        phase_i,
  input  logic [7:0]        held_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output pec_pkg::pec_burst_t burst_o,
  output logic [1:0]        phase_o,
  output logic [7:0]        held_o
);
  import pec_pkg::*;

  logic [1:0] n;
  logic [1:0] ph;
  logic       c_hex;
  logic       c_pct;

  assign c_hex = is_hex(in_byte_i);
  assign c_pct = (in_byte_i == PCT_CHAR);

  always_comb begin
    n             = 2'd0;
    ph            = phase_i;
    held_o        = held_i;
    burst_o.bytes = '0;
    burst_o.last  = in_last_i;
    if (!mode_i) begin
      if (is_unreserved(in_byte_i)) begin
        burst_o.bytes[0] = in_byte_i;
        n                = 2'd1;
      end else begin
        burst_o.bytes[0] = PCT_CHAR;
        burst_o.bytes[1] = HEX_DIGITS[in_byte_i[7:4]];
        burst_o.bytes[2] = HEX_DIGITS[in_byte_i[3:0]];
        n                = 2'd3;
      end
    end else begin
      unique case (phase_i)
        PH_PCT: begin
          if (c_hex) begin
            ph     = PH_DIG;
            held_o = in_byte_i;
          end else begin
            burst_o.bytes[0] = PCT_CHAR;
            n                = 2'd1;
            ph               = PH_IDLE;
          end
        end
        PH_DIG: begin
          if (c_hex) begin
            burst_o.bytes[0] = {hex_val(held_i), hex_val(in_byte_i)};
            n                = 2'd1;
            ph               = PH_IDLE;
            held_o           = 8'h00;
          end else begin
            burst_o.bytes[0] = PCT_CHAR;
            burst_o.bytes[1] = held_i;
            n                = 2'd2;
            ph               = PH_IDLE;
            held_o           = 8'h00;
          end
        end
        default: ph = PH_IDLE;
      endcase
      // the breaking byte (or a byte seen from idle) is examined afresh
      if (ph == PH_IDLE && !(phase_i == PH_DIG && c_hex)) begin
        if (c_pct) begin
          ph = PH_PCT;
        end else begin
          burst_o.bytes[n] = in_byte_i;
          n                = n + 2'd1;
        end
      end
      // end of string: flush a pending '%' and held digit
      if (in_last_i) begin
        if (ph == PH_PCT) begin
          burst_o.bytes[n] = PCT_CHAR;
          n                = n + 2'd1;
        end else if (ph == PH_DIG) begin
          burst_o.bytes[0] = PCT_CHAR;
          burst_o.bytes[1] = held_o;
          n                = 2'd2;
        end
        ph     = PH_IDLE;
        held_o = 8'h00;
      end
    end
    burst_o.cnt = n;
    phase_o     = ph;
  end

endmodule

FILE: rtl/pec_burst.sv
// Result buffer for one item's burst plus the output register that feeds the port.
module pec_burst (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  pec_pkg::pec_burst_t burst_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o
);
  import pec_pkg::*;

  logic [1:0]              rem_q;
  logic [MAX_RES-1:0][7:0] bytes_q;
  logic                    last_q;
  logic                    ov_q;
  logic [7:0]              ob_q;
  logic                    ol_q;
  logic                    pop;

  assign pop        = (rem_q != 2'd0) && (!ov_q || out_ready_i);
  assign can_load_o = (rem_q == 2'd0) || (rem_q == 2'd1 && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      ov_q  <= 1'b0;
    end else begin
      if (load_i) begin
        rem_q <= burst_i.cnt;
      end else if (pop) begin
        rem_q <= rem_q - 2'd1;
      end
      if (pop) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= burst_i.bytes;
      last_q  <= burst_i.last;
    end else if (pop) begin
      bytes_q <= {8'h00, bytes_q[MAX_RES-1:1]};
    end
    if (pop) begin
      ob_q <= bytes_q[0];
      ol_q <= last_q && (rem_q == 2'd1);
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;

endmodule

FILE: rtl/percent_encoding_codec_core.sv
// Results of an input transfer load the three-entry result buffer and move one at a
// time into the output register on the port. Throughput: one output byte per cycle
// while the output is ready; the next item loads as the last result leaves, so
// single-result items stream at one per cycle. The single output port is the limit.
// Reset (asynchronous, active low) clears mode to encode, the decode phase,
// the held digit and all valid state.
module percent_encoding_codec_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import pec_pkg::*;

  logic       mode_q;
  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       in_xfer;
  pec_burst_t burst;

  assign in_xfer = in_valid_i && in_ready_o;

  pec_step u_step (
    .mode_i    (mode_q),
    .phase_i   (phase_q),
    .held_i    (held_q),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .burst_o   (burst),
    .phase_o   (phase_d),
    .held_o    (held_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      phase_q <= PH_IDLE;
      held_q  <= 8'h00;
    end else if (cfg_we_i) begin
      // any mode write drops pending decode state
      mode_q  <= cfg_wdata_i;
      phase_q <= PH_IDLE;
      held_q  <= 8'h00;
    end else if (in_xfer) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  pec_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_xfer),
    .burst_i     (burst),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

FILE: rtl/pec_checker.sv
// Port-level assertions for the percent-encoding codec, bound to the top level.
module pec_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic       cfg_wdata_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       in_last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);
  import pec_pkg::*;

  logic       mode_q;
  logic [1:0] ends_q;
  logic       in_end;
  logic       out_end;

  assign in_end  = in_valid_i && in_ready_o && in_last_i;
  assign out_end = out_valid_o && out_ready_i && out_last_o;

  // string ends accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      ends_q <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      ends_q <= ends_q + {1'b0, in_end} - {1'b0, out_end};
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(out_last_o))
    else $error("stalled output changed");

  a_end_follows_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_end |-> ends_q != 2'd0)
    else $error("end-of-string transfer with no string end accepted");

  a_encode_alphabet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_q |-> is_unreserved(out_byte_o) || out_byte_o == PCT_CHAR)
    else $error("encoded output holds a reserved byte");

endmodule

bind percent_encoding_codec_core pec_checker u_pec_checker (.*);
